/* hdl/tked_pkg.sv */
package tked_pkg;

   localparam logic [7:0] ESC_BYTE     = 8'h1B;
   localparam logic [7:0] CHAR_LBRACK  = 8'h5B;  // '['
   localparam logic [7:0] CHAR_O       = 8'h4F;  // 'O'
   localparam logic [7:0] CHAR_TILDE   = 8'h7E;  // '~'
   localparam logic [7:0] CHAR_A       = 8'h41;
   localparam logic [7:0] CHAR_B       = 8'h42;
   localparam logic [7:0] CHAR_C       = 8'h43;
   localparam logic [7:0] CHAR_D       = 8'h44;
   localparam logic [7:0] CHAR_H       = 8'h48;
   localparam logic [7:0] CHAR_F       = 8'h46;
   localparam logic [7:0] CHAR_0       = 8'h30;
   localparam logic [7:0] CHAR_9       = 8'h39;
   localparam logic [7:0] CHAR_3       = 8'h33;
   localparam logic [7:0] CHAR_5       = 8'h35;
   localparam logic [7:0] CHAR_6       = 8'h36;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_ESC   = 2'd1,
      PH_FIRST = 2'd2,
      PH_DIGIT = 2'd3
   } phase_type;

   typedef enum logic [3:0] {
      K_PLAIN = 4'd0,
      K_ESC   = 4'd1,
      K_UP    = 4'd2,
      K_DOWN  = 4'd3,
      K_RIGHT = 4'd4,
      K_LEFT  = 4'd5,
      K_HOME  = 4'd6,
      K_END   = 4'd7,
      K_DEL   = 4'd8,
      K_PGUP  = 4'd9,
      K_PGDN  = 4'd10
   } key_kind_type;

   typedef struct packed {
      logic         emit;
      key_kind_type kind;
      logic [7:0]   plain_char;
   } dec_out_type;

endpackage

/* hdl/tked_decode.sv */
module tked_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [7:0]           rx_byte,
   input  logic                 is_timeout,
   output tked_pkg::dec_out_type dec
);

   tked_pkg::phase_type phase_ff, phase_in;
   logic [7:0] first_seq_byte_ff, first_seq_byte_in;
   logic [7:0] digit_byte_ff, digit_byte_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= tked_pkg::PH_IDLE;
         first_seq_byte_ff <= '0;
         digit_byte_ff     <= '0;
      end else if (advance) begin
         phase_ff          <= phase_in;
         first_seq_byte_ff <= first_seq_byte_in;
         digit_byte_ff     <= digit_byte_in;
      end
   end

   always_comb begin
      phase_in          = phase_ff;
      first_seq_byte_in = first_seq_byte_ff;
      digit_byte_in     = digit_byte_ff;
      dec.emit          = 1'b0;
      dec.kind          = tked_pkg::K_PLAIN;
      dec.plain_char    = '0;
      case (phase_ff)
         tked_pkg::PH_IDLE: begin
            if (!is_timeout) begin
               if (rx_byte == tked_pkg::ESC_BYTE) begin
                  phase_in = tked_pkg::PH_ESC;
               end else begin
                  dec.emit       = 1'b1;
                  dec.plain_char = rx_byte;
               end
            end
         end
         tked_pkg::PH_ESC: begin
            if (is_timeout) begin
               dec.emit = 1'b1;
               dec.kind = tked_pkg::K_ESC;
               phase_in = tked_pkg::PH_IDLE;
            end else begin
               first_seq_byte_in = rx_byte;
               phase_in          = tked_pkg::PH_FIRST;
            end
         end
         tked_pkg::PH_FIRST: begin
            // unrecognized pair falls back to after-esc
            phase_in = tked_pkg::PH_ESC;
            if (is_timeout) begin
               dec.emit = 1'b1;
               dec.kind = tked_pkg::K_ESC;
            end else if (first_seq_byte_ff == tked_pkg::CHAR_LBRACK) begin
               if (rx_byte >= tked_pkg::CHAR_0 && rx_byte <= tked_pkg::CHAR_9) begin
                  digit_byte_in = rx_byte;
                  phase_in      = tked_pkg::PH_DIGIT;
               end else begin
                  case (rx_byte)
                     tked_pkg::CHAR_A: begin dec.emit = 1'b1; dec.kind = tked_pkg::K_UP; end
                     tked_pkg::CHAR_B: begin dec.emit = 1'b1; dec.kind = tked_pkg::K_DOWN; end
                     tked_pkg::CHAR_C: begin dec.emit = 1'b1; dec.kind = tked_pkg::K_RIGHT; end
                     tked_pkg::CHAR_D: begin dec.emit = 1'b1; dec.kind = tked_pkg::K_LEFT; end
                     tked_pkg::CHAR_H: begin dec.emit = 1'b1; dec.kind = tked_pkg::K_HOME; end
                     tked_pkg::CHAR_F: begin dec.emit = 1'b1; dec.kind = tked_pkg::K_END; end
                     default: ;
                  endcase
               end
            end else if (first_seq_byte_ff == tked_pkg::CHAR_O) begin
               if (rx_byte == tked_pkg::CHAR_H) begin
                  dec.emit = 1'b1;
                  dec.kind = tked_pkg::K_HOME;
               end else if (rx_byte == tked_pkg::CHAR_F) begin
                  dec.emit = 1'b1;
                  dec.kind = tked_pkg::K_END;
               end
            end
            if (dec.emit) begin
               phase_in = tked_pkg::PH_IDLE;
            end
         end
         tked_pkg::PH_DIGIT: begin
            phase_in = tked_pkg::PH_ESC;
            if (is_timeout) begin
               dec.emit = 1'b1;
               dec.kind = tked_pkg::K_ESC;
            end else if (rx_byte == tked_pkg::CHAR_TILDE) begin
               if (digit_byte_ff == tked_pkg::CHAR_3) begin
                  dec.emit = 1'b1;
                  dec.kind = tked_pkg::K_DEL;
               end else if (digit_byte_ff == tked_pkg::CHAR_5) begin
                  dec.emit = 1'b1;
                  dec.kind = tked_pkg::K_PGUP;
               end else if (digit_byte_ff == tked_pkg::CHAR_6) begin
                  dec.emit = 1'b1;
                  dec.kind = tked_pkg::K_PGDN;
               end
            end
            if (dec.emit) begin
               phase_in = tked_pkg::PH_IDLE;
            end
         end
         default: begin
            phase_in = tked_pkg::PH_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // a timeout while idle never produces a key
   a_idle_timeout_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == tked_pkg::PH_IDLE && is_timeout) |-> !dec.emit)
      else $error("timeout while idle produced a key");

   // every emitted key returns the parser to idle
   a_emit_to_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && dec.emit) |=> phase_ff == tked_pkg::PH_IDLE)
      else $error("parser not idle after a key");

   // only an idle plain key carries a character
   a_char_only_plain: assert property (@(posedge clock) disable iff (reset)
      (dec.emit && dec.kind != tked_pkg::K_PLAIN) |-> dec.plain_char == 8'd0)
      else $error("non-plain key with character");
`endif

endmodule

/* hdl/terminal_key_escape_decoder.sv */
// terminal key escape decoder
//
// req channel: one word per byte from the terminal (req_rx_byte), or a read
// timeout tick (req_is_timeout high, byte ignored). a word is taken at a
// rising edge with req_valid high and req_stall low.
// rsp channel: zero or one key per request word, rsp_key_kind plus
// rsp_plain_char (the byte for plain keys, zero otherwise). a key leaves at
// an edge with rsp_valid high and rsp_stall low.
// path: a taken word waits in the input register, is decoded from there, and
// its key, if any, is loaded into the result register as the word moves on;
// the key leaves from the result register.
// throughput: one word per cycle while req_stall is low; the parser state is a
// handful of flops updated as the word leaves the input register.
// stall: while a key waits in the result register the next word is still
// decoded if it produces no key; a word that produces a key waits in the
// input register, and req_stall is raised only when that register is full
// and cannot move on.
// reset: synchronous, active high; both registers empty, parser idle.
module terminal_key_escape_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_is_timeout,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_key_kind,
   output logic [7:0] rsp_plain_char
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_tmo_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic [3:0] out_kind_ff;
   logic [7:0] out_char_ff;

   tked_pkg::dec_out_type dec;
   logic out_free;
   logic advance;
   logic req_take;

   // result register can take a key this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   // input word moves on if it needs no slot or one is free
   assign advance   = in_valid_ff && (out_free || !dec.emit);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   tked_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .rx_byte    (in_byte_ff),
      .is_timeout (in_tmo_ff),
      .dec        (dec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
         in_tmo_ff  <= req_is_timeout;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (advance && dec.emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && dec.emit) begin
         out_kind_ff <= dec.kind;
         out_char_ff <= dec.plain_char;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_key_kind   = out_kind_ff;
   assign rsp_plain_char = out_char_ff;

`ifndef SYNTHESIS
   // a key is never loaded over one that is still held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (advance && dec.emit) |-> out_free)
      else $error("result register overwritten");

   // a word is only taken when the input register drains or is empty
   a_in_slot: assert property (@(posedge clock) disable iff (reset)
      req_take |-> (!in_valid_ff || advance))
      else $error("input register overrun");

   // key codes stay within the defined set
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_kind_ff <= tked_pkg::K_PGDN)
      else $error("undefined key code");
`endif

endmodule
